// ===== design/assert_macros.svh =====
// Assertion macros used by kpft_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== design/kpft_pkg.sv =====
// ---------------------------------------------------------------------------
// kpft_pkg
// Types and constants of the keyed policy flag table.
// ---------------------------------------------------------------------------
package kpft_pkg;
	localparam int unsigned TableDepth = 64;
	localparam int unsigned IdxW = 6;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0, ACT_ADD = 3'd1, ACT_REMOVE = 3'd2,
		ACT_UPDATE = 3'd3, ACT_CLEAR = 3'd4, ACT_TEST = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0, ERR_NOT_FOUND = 2'd1, ERR_PRESENT = 2'd2, ERR_FULL = 2'd3
	} err_t;

	localparam logic CFG_HIDE = 1'b0;
	localparam logic CFG_LOCK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_FIX, ST_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [31:0] flags;
		logic [31:0] version;
	} entry_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [31:0] new_flags;
		logic [31:0] new_version;
		logic [31:0] flag_mask;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [5:0]  found_index;
		logic [31:0] entry_flags;
		logic [31:0] entry_version;
		logic        any_hidden;
		logic        any_locked;
		logic [1:0]  error_code;
	} rsp_t;
endpackage

// ===== design/kpft_if.sv =====
// ---------------------------------------------------------------------------
// kpft_req_if / kpft_rsp_if
// Valid/ready channels carrying request and response words.
// ---------------------------------------------------------------------------
interface kpft_req_if;
	logic            valid;
	logic            ready;
	kpft_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kpft_rsp_if;
	logic            valid;
	logic            ready;
	kpft_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/kpft_cell.sv =====
// ---------------------------------------------------------------------------
// kpft_cell
// One table slot. Holds an entry; in rotate mode takes its neighbor's entry.
// ---------------------------------------------------------------------------
module kpft_cell (
	input  logic             clk,
	input  logic             rotate,
	input  logic             load,
	input  kpft_pkg::entry_t load_entry,
	input  kpft_pkg::entry_t prev_entry,
	output kpft_pkg::entry_t entry
);
	import kpft_pkg::*;
	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
		end else if (rotate) begin
			entry_q <= prev_entry;
		end
	end

	assign entry = entry_q;
endmodule

// ===== design/keyed_policy_flag_table.sv =====
// Keyed policy flag table: a ring of TABLE_DEPTH cells that rotates past slot 0.
// A request is taken in ST_IDLE; the ring makes one full rotation in ST_SCAN,
// ST_FIX writes the edit and registers the response, and ST_DONE presents it
// until rsp.ready. The next word is taken back in ST_IDLE, in the cycle after
// the response is accepted. Reset (arst_n low) empties the table and
// restores the default masks; entry contents stay undefined until written.
module keyed_policy_flag_table #(
	parameter int unsigned TABLE_DEPTH = kpft_pkg::TableDepth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	kpft_req_if.sink                req,
	kpft_rsp_if.source              rsp,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data
);
	import kpft_pkg::*;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned SW = $clog2(TABLE_DEPTH);

	state_t state_q, state_d;
	req_t req_q;
	rsp_t rsp_q, rsp_d;
	logic [31:0] hide_q, lock_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] step_q;
	logic hit_q, hid_q, lck_q;
	logic [SW-1:0] slot_q;
	entry_t hit_entry_q, last_entry_q;

	entry_t cells [TABLE_DEPTH];
	logic load [TABLE_DEPTH];
	entry_t load_e [TABLE_DEPTH];
	logic rotate;

	// liveness and key match of the entry now at cell 0 during the scan
	logic live0, match0;
	assign live0 = (CW'(step_q) < count_q);
	assign match0 = live0 && cells[0].key_high == req_q.key_high &&
		cells[0].key_low == req_q.key_low;
	assign rotate = (state_q == ST_SCAN);

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		kpft_cell u_cell (
			.clk(clk), .rotate(rotate), .load(load[g]), .load_entry(load_e[g]),
			.prev_entry(cells[(g + 1) % TABLE_DEPTH]), .entry(cells[g])
		);
	end

	// fixup writes after a full rotation (cells back in place)
	logic do_add, do_rem, do_upd;
	always_comb begin
		do_add = req_q.action == ACT_ADD && !hit_q && count_q < CW'(TABLE_DEPTH);
		do_rem = req_q.action == ACT_REMOVE && hit_q;
		do_upd = req_q.action == ACT_UPDATE && hit_q;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			load[i] = 1'b0;
			load_e[i] = last_entry_q;
			if (state_q == ST_FIX) begin
				if (do_add && count_q == CW'(i)) begin
					load[i] = 1'b1;
					load_e[i] = '{req_q.key_high, req_q.key_low, req_q.new_flags, 32'd0};
				end else if (do_rem && slot_q == SW'(i)) begin
					load[i] = 1'b1;
					load_e[i] = last_entry_q;
				end else if (do_upd && slot_q == SW'(i)) begin
					load[i] = 1'b1;
					load_e[i] = '{hit_entry_q.key_high, hit_entry_q.key_low,
						req_q.new_flags, req_q.new_version};
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req.valid) state_d = ST_SCAN;
			ST_SCAN: if (step_q == SW'(TABLE_DEPTH - 1)) state_d = ST_FIX;
			ST_FIX:  state_d = ST_DONE;
			ST_DONE: if (rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_DONE);
	assign rsp.data = rsp_q;

	// summary over the final table contents
	logic [CW-1:0] new_count;
	logic summ_h, summ_l;
	always_comb begin
		new_count = count_q;
		if (req_q.action == ACT_CLEAR) new_count = '0;
		else if (do_add) new_count = count_q + 1'b1;
		else if (do_rem) new_count = count_q - 1'b1;
		// scan accumulated over old entries except the edited ones; add edits
		summ_h = hid_q;
		summ_l = lck_q;
		if (do_add) begin
			summ_h = summ_h | (|(req_q.new_flags & hide_q));
			summ_l = summ_l | (|(req_q.new_flags & lock_q));
		end
		if (do_upd) begin
			summ_h = summ_h | (|(req_q.new_flags & hide_q));
			summ_l = summ_l | (|(req_q.new_flags & lock_q));
		end
		if (req_q.action == ACT_CLEAR) begin
			summ_h = 1'b0;
			summ_l = 1'b0;
		end
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.any_hidden = summ_h;
		rsp_d.any_locked = summ_l;
		unique case (req_q.action)
			ACT_LOOKUP, ACT_TEST: begin
				if (hit_q) begin
					rsp_d.found_index = 6'(slot_q);
					rsp_d.entry_flags = hit_entry_q.flags;
					rsp_d.entry_version = hit_entry_q.version;
					rsp_d.ok = (req_q.action == ACT_LOOKUP) ||
						(|(hit_entry_q.flags & req_q.flag_mask));
				end else rsp_d.error_code = ERR_NOT_FOUND;
			end
			ACT_ADD: begin
				if (hit_q) begin
					rsp_d.error_code = ERR_PRESENT;
					rsp_d.found_index = 6'(slot_q);
					rsp_d.entry_flags = hit_entry_q.flags;
					rsp_d.entry_version = hit_entry_q.version;
				end else if (!do_add) rsp_d.error_code = ERR_FULL;
				else begin
					rsp_d.ok = 1'b1;
					rsp_d.found_index = 6'(count_q);
					rsp_d.entry_flags = req_q.new_flags;
				end
			end
			ACT_REMOVE: begin
				if (hit_q) begin
					rsp_d.ok = 1'b1;
					rsp_d.found_index = 6'(slot_q);
					rsp_d.entry_flags = hit_entry_q.flags;
					rsp_d.entry_version = hit_entry_q.version;
				end else rsp_d.error_code = ERR_NOT_FOUND;
			end
			ACT_UPDATE: begin
				if (hit_q) begin
					rsp_d.ok = 1'b1;
					rsp_d.found_index = 6'(slot_q);
					rsp_d.entry_flags = req_q.new_flags;
					rsp_d.entry_version = req_q.new_version;
				end else rsp_d.error_code = ERR_NOT_FOUND;
			end
			ACT_CLEAR: rsp_d.ok = 1'b1;
			default: ;
		endcase
	end

	// scan flags: entries other than the hit slot (and the last slot on remove
	// contributes via its moved copy, so it is counted once anyway)
	logic exclude0;
	assign exclude0 = (req_q.action == ACT_UPDATE) && match0 && !hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			hide_q <= 32'd1;
			lock_q <= 32'd2;
			step_q <= '0;
			hit_q <= 1'b0;
			hid_q <= 1'b0;
			lck_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_HIDE) hide_q <= cfg_data;
				else lock_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					hit_q <= 1'b0;
					hid_q <= 1'b0;
					lck_q <= 1'b0;
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (match0 && !hit_q) hit_q <= 1'b1;
					// removed entry drops out; updated entry re-added in fixup
					if (live0 && !exclude0 &&
						!(req_q.action == ACT_REMOVE && match0 && !hit_q)) begin
						if (|(cells[0].flags & hide_q)) hid_q <= 1'b1;
						if (|(cells[0].flags & lock_q)) lck_q <= 1'b1;
					end
				end
				ST_FIX: count_q <= new_count;
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) req_q <= req.data;
		if (state_q == ST_SCAN) begin
			if (match0 && !hit_q) begin
				slot_q <= step_q;
				hit_entry_q <= cells[0];
			end
			if (CW'(step_q) == count_q - 1'b1) last_entry_q <= cells[0];
		end
		if (state_q == ST_FIX) rsp_q <= rsp_d;
	end
endmodule

// ===== design/kpft_checker.sv =====
// ---------------------------------------------------------------------------
// kpft_checker
// Port-level checks of the keyed policy flag table.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module kpft_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input kpft_pkg::rsp_t rsp_data
);
	import kpft_pkg::*;
	logic full_err;
	assign full_err = rsp_valid && rsp_data.error_code == ERR_FULL;

	`ASSERT_IMPL(a_one_at_a_time, clk, arst_n, rsp_valid, !req_ready)
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, req_valid && req_ready, !req_ready && !rsp_valid)
	`ASSERT_IMPL(a_ok_no_err, clk, arst_n, rsp_valid && rsp_data.ok, rsp_data.error_code == ERR_NONE)
	`ASSERT_IMPL(a_err_zero_idx, clk, arst_n, full_err, rsp_data.found_index == 6'd0)
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule

bind keyed_policy_flag_table kpft_checker u_kpft_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Checks the keyed policy flag table against a behavioral table model: random
// and directed requests (add/lookup/update/remove/test/clear, full table and
// duplicates), mask reprogramming between phases, random idle and stall.
// ---------------------------------------------------------------------------
class flag_table_board;
	logic [63:0] kh [kpft_pkg::TableDepth];
	logic [63:0] kl [kpft_pkg::TableDepth];
	logic [31:0] fl [kpft_pkg::TableDepth];
	logic [31:0] vr [kpft_pkg::TableDepth];
	int unsigned live;
	logic [31:0] hide_mask;
	logic [31:0] lock_mask;
	kpft_pkg::rsp_t pending[$];
	int errors;

	function void clear_state();
		live = 0;
		hide_mask = 32'd1;
		lock_mask = 32'd2;
		pending.delete();
	endfunction

	function void note_request(kpft_pkg::req_t r);
		kpft_pkg::rsp_t o;
		int slot;
		slot = -1;
		o = '0;
		if (r.action <= kpft_pkg::ACT_TEST && r.action != kpft_pkg::ACT_CLEAR)
			for (int i = int'(live) - 1; i >= 0; i--)
				if (kh[i] == r.key_high && kl[i] == r.key_low) slot = i;
		case (r.action)
			kpft_pkg::ACT_LOOKUP, kpft_pkg::ACT_TEST: begin
				if (slot >= 0) begin
					o.found_index = 6'(slot);
					o.entry_flags = fl[slot];
					o.entry_version = vr[slot];
					o.ok = (r.action == kpft_pkg::ACT_LOOKUP) ? 1'b1 :
						((fl[slot] & r.flag_mask) != 0);
				end else o.error_code = kpft_pkg::ERR_NOT_FOUND;
			end
			kpft_pkg::ACT_ADD: begin
				if (slot >= 0) begin
					o.error_code = kpft_pkg::ERR_PRESENT;
					o.found_index = 6'(slot);
					o.entry_flags = fl[slot];
					o.entry_version = vr[slot];
				end else if (live >= kpft_pkg::TableDepth) o.error_code = kpft_pkg::ERR_FULL;
				else begin
					kh[live] = r.key_high;
					kl[live] = r.key_low;
					fl[live] = r.new_flags;
					vr[live] = '0;
					o.ok = 1'b1;
					o.found_index = 6'(live);
					o.entry_flags = r.new_flags;
					live++;
				end
			end
			kpft_pkg::ACT_REMOVE: begin
				if (slot >= 0) begin
					o.ok = 1'b1;
					o.found_index = 6'(slot);
					o.entry_flags = fl[slot];
					o.entry_version = vr[slot];
					kh[slot] = kh[live - 1];
					kl[slot] = kl[live - 1];
					fl[slot] = fl[live - 1];
					vr[slot] = vr[live - 1];
					live--;
				end else o.error_code = kpft_pkg::ERR_NOT_FOUND;
			end
			kpft_pkg::ACT_UPDATE: begin
				if (slot >= 0) begin
					fl[slot] = r.new_flags;
					vr[slot] = r.new_version;
					o.ok = 1'b1;
					o.found_index = 6'(slot);
					o.entry_flags = r.new_flags;
					o.entry_version = r.new_version;
				end else o.error_code = kpft_pkg::ERR_NOT_FOUND;
			end
			kpft_pkg::ACT_CLEAR: begin
				live = 0;
				o.ok = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < live; i++) begin
			if ((fl[i] & hide_mask) != 0) o.any_hidden = 1'b1;
			if ((fl[i] & lock_mask) != 0) o.any_locked = 1'b1;
		end
		pending.push_back(o);
	endfunction

	function void check_response(kpft_pkg::rsp_t got);
		kpft_pkg::rsp_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected response %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected %h actual %h", want, got);
		end
	endfunction
endclass

module tb;
	import kpft_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;
	kpft_req_if req ();
	kpft_rsp_if rsp ();
	flag_table_board board;
	logic [63:0] key_pool_h [16];
	logic [63:0] key_pool_l [16];
	int hold_off;
	int idle_cycles;

	keyed_policy_flag_table dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// valid stays up after an accept until the next word or an idle gap
	task automatic send_word(req_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		board.note_request(r);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HIDE) board.hide_mask = v;
		else board.lock_mask = v;
		@(posedge clk);
	endtask

	function automatic req_t make_word(logic [2:0] a, int k);
		req_t r;
		r.action = a;
		r.key_high = key_pool_h[k];
		r.key_low = key_pool_l[k];
		r.new_flags = $urandom >> $urandom_range(0, 31);
		r.new_version = $urandom;
		r.flag_mask = $urandom;
		return r;
	endfunction

	function automatic req_t rand_word();
		req_t r;
		int p;
		p = $urandom_range(0, 99);
		if (p < 30) r = make_word(ACT_ADD, $urandom_range(0, 15));
		else if (p < 45) r = make_word(ACT_LOOKUP, $urandom_range(0, 15));
		else if (p < 60) r = make_word(ACT_REMOVE, $urandom_range(0, 15));
		else if (p < 75) r = make_word(ACT_UPDATE, $urandom_range(0, 15));
		else if (p < 90) r = make_word(ACT_TEST, $urandom_range(0, 15));
		else if (p < 92) r = make_word(ACT_CLEAR, 0);
		else begin
			r = make_word(3'($urandom_range(0, 7)), 0);
			r.key_high = {$urandom, $urandom};
			r.key_low = {$urandom, $urandom};
		end
		return r;
	endfunction

	// response side, with a long hold-off when requested
	initial begin
		int g;
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off > 0) begin
				rsp.ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			g = gap_len();
			if (g > 0) begin
				rsp.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			if (rsp.valid && rsp.ready) board.check_response(rsp.data);
		end
	end

	// watchdog
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 3000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		req_t r;
		board = new();
		board.clear_state();
		board.errors = 0;
		hold_off = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < 16; i++) begin
			key_pool_h[i] = {$urandom, $urandom};
			key_pool_l[i] = {$urandom, $urandom};
		end
		key_pool_h[0] = '0; key_pool_l[0] = '0;
		key_pool_h[1] = '1; key_pool_l[1] = '1;
		key_pool_h[2] = '0; key_pool_l[2] = '1;
		key_pool_h[3] = '1; key_pool_l[3] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses on empty, add, duplicate, each action, fill to full
		r = make_word(ACT_LOOKUP, 0); send_word(r);
		r = make_word(ACT_REMOVE, 1); send_word(r);
		r = make_word(ACT_ADD, 0); r.new_flags = '1; send_word(r);
		r = make_word(ACT_ADD, 0); send_word(r);
		r = make_word(ACT_ADD, 1); r.new_flags = '0; send_word(r);
		r = make_word(ACT_UPDATE, 1); r.new_flags = 32'h2; r.new_version = '1;
		send_word(r);
		r = make_word(ACT_TEST, 1); r.flag_mask = 32'h2; send_word(r);
		r = make_word(ACT_TEST, 1); r.flag_mask = 32'hFFFF_FFFD; send_word(r);
		r = make_word(ACT_TEST, 2); send_word(r);
		r = make_word(ACT_REMOVE, 0); send_word(r);
		r = make_word(ACT_LOOKUP, 1); send_word(r);
		r = make_word(3'd6, 0); send_word(r);
		r = make_word(3'd7, 1); send_word(r);
		r = make_word(ACT_CLEAR, 0); send_word(r);
		// full table with the response side held off
		hold_off = 150;
		for (int i = 0; i < 65; i++) begin
			r = make_word(ACT_ADD, 0);
			r.key_low = 64'(i);
			send_word(r);
		end
		r = make_word(ACT_ADD, 5); send_word(r);
		r = make_word(ACT_REMOVE, 0); r.key_low = 64'd0; send_word(r);
		r = make_word(ACT_LOOKUP, 0); r.key_low = 64'd63; send_word(r);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_HIDE, 32'h0); write_reg(CFG_LOCK, 32'hFFFF_FFFF); end
				1: begin write_reg(CFG_HIDE, 32'hFFFF_FFFF); write_reg(CFG_LOCK, 32'h0); end
				2: begin write_reg(CFG_HIDE, 32'h8000_0000); write_reg(CFG_LOCK, 32'h1); end
				default: begin write_reg(CFG_HIDE, $urandom); write_reg(CFG_LOCK, $urandom); end
			endcase
			for (int n = 0; n < 300; n++) send_word(rand_word());
			if (ph == 3) begin
				// table filled to full by add-heavy traffic
				for (int n = 0; n < 70; n++) begin
					r = make_word(ACT_ADD, 0);
					r.key_high = {$urandom, $urandom};
					send_word(r);
				end
			end
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
